### rtl/unified_cordic_engine_macros.svh
// assertion macros shared by the cordic engine
`ifndef UNIFIED_CORDIC_ENGINE_MACROS_SVH
`define UNIFIED_CORDIC_ENGINE_MACROS_SVH

// same-cycle implication, checked outside reset
`define UCE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/uce_pkg.sv
// shared types, mode codes and constant angle and gain tables for the cordic engine
package uce_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 28;
    localparam int ITERATIONS  = 28;
    localparam int TABLE_DEPTH = 27;

    localparam logic [1:0] FUNC_CIRC  = 2'd0;
    localparam logic [1:0] FUNC_LIN   = 2'd1;
    localparam logic [1:0] FUNC_HYP   = 2'd2;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    localparam logic [63:0] Q62_ONE = 64'd1 << 62;

    typedef struct packed {
        logic [1:0]            func;
        logic                  vec;
        logic [DATA_WIDTH-1:0] x;
        logic [DATA_WIDTH-1:0] y;
        logic [DATA_WIDTH-1:0] z;
    } beat_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] x;
        logic [DATA_WIDTH-1:0] y;
        logic [DATA_WIDTH-1:0] z;
    } res_t;

    // per-pass constants of one mode
    typedef struct packed {
        logic                  active;
        logic [5:0]            shift;
        logic [DATA_WIDTH-1:0] step;
    } sched_t;

    // shift-subtract quotient, used for the constant tables only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          b;
        rem = '0;
        quo = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] sext64(input logic [63:0] v);
        logic [63:0] m;
        m = ~64'd0 >> (64 - DATA_WIDTH);
        if (v[DATA_WIDTH-1])
            return v | ~m;
        return v & m;
    endfunction

    // atan(1/n) or atanh(1/n) in q63 by series
    function automatic logic [63:0] series_recip(input logic [63:0] n, input logic hyp);
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] t;
        int          k;
        p = udiv64(64'd1 << 63, n);
        s = '0;
        for (k = 0; k < 40; k++)
        begin
            if (p != 64'd0)
            begin
                t = udiv64(p, 64'(2 * k + 1));
                if (hyp || !k[0])
                    s = s + t;
                else
                    s = s - t;
                p = udiv64(p, n * n);
            end
        end
        return s;
    endfunction

    // atan(2^-i) or atanh(2^-i) in q63
    function automatic logic [63:0] series_pow2(input int i, input logic hyp);
        logic [63:0] s;
        logic [63:0] t;
        int          k;
        s = '0;
        for (k = 0; k < 32; k++)
        begin
            if ((i * (2 * k + 1)) < 64)
            begin
                t = udiv64((64'd1 << 63) >> (i * (2 * k + 1)), 64'(2 * k + 1));
                if (hyp || !k[0])
                    s = s + t;
                else
                    s = s - t;
            end
        end
        return s;
    endfunction

    function automatic logic [63:0] q63_to_frac(input logic [63:0] v);
        return (v + (64'd1 << (62 - FRAC_BITS))) >> (63 - FRAC_BITS);
    endfunction

    function automatic logic [63:0] rom_entry(input logic hyp, input int i);
        logic [63:0] v;
        if (i == 0)
        begin
            if (hyp)
                v = '0;
            else
                v = q63_to_frac(64'd4 * series_recip(64'd5, 1'b0)
                                - series_recip(64'd239, 1'b0));
        end
        else
        begin
            v = q63_to_frac(series_pow2(i, hyp));
        end
        return v;
    endfunction

    function automatic logic [63:0] mulq62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] inv_sqrt_frac(input logic [63:0] p);
        logic [63:0] y;
        logic [63:0] t;
        int          n;
        y = 64'd3 * (Q62_ONE >> 2);
        for (n = 0; n < 40; n++)
        begin
            t = mulq62(p, mulq62(y, y));
            y = mulq62(y, 64'd3 * Q62_ONE - t) >> 1;
        end
        return (y + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    endfunction

    // product of the squared pass stretch factors in q62
    function automatic logic [63:0] gain_prod(input logic hyp);
        logic [63:0] pr;
        int          i;
        int          rep;
        pr  = Q62_ONE;
        rep = 1;
        if (!hyp)
        begin
            for (i = 0; i < ITERATIONS; i++)
                if (2 * i < 64)
                    pr = pr + (pr >> (2 * i));
        end
        else
        begin
            for (i = 1; i < ITERATIONS; i++)
            begin
                if (2 * i < 64)
                    pr = pr - (pr >> (2 * i));
                if (i == rep)
                begin
                    rep = rep * 3 + 1;
                    if (2 * i < 64)
                        pr = pr - (pr >> (2 * i));
                end
            end
        end
        return pr;
    endfunction

    // number of passes run in a mode
    function automatic int pass_count(input logic [1:0] fn);
        int i;
        int rep;
        int n;
        rep = 1;
        n   = 0;
        for (i = (fn == FUNC_HYP) ? 1 : 0; i < ITERATIONS; i++)
        begin
            if (fn == FUNC_HYP && i == rep)
            begin
                n   = n + 2;
                rep = rep * 3 + 1;
            end
            else
            begin
                n = n + 1;
            end
        end
        return n;
    endfunction

    // shift, angle step and enable of pass p in a mode
    function automatic sched_t pass_sched(input logic [1:0] fn, input int p);
        sched_t      r;
        int          i;
        int          pass;
        int          passes;
        int          rep;
        int          n;
        int          src;
        int          halves;
        int          cap_src;
        int          cap_halves;
        logic        use_rom;
        logic        cap_rom;
        logic [63:0] step;
        r          = '0;
        rep        = 1;
        n          = 0;
        src        = 0;
        halves     = 0;
        cap_src    = 0;
        cap_halves = 0;
        use_rom    = 1'b0;
        cap_rom    = 1'b0;
        step       = '0;
        for (i = (fn == FUNC_HYP) ? 1 : 0; i < ITERATIONS; i++)
        begin
            passes = (fn == FUNC_HYP && i == rep) ? 2 : 1;
            for (pass = 0; pass < passes; pass++)
            begin
                if (i < TABLE_DEPTH && (fn == FUNC_CIRC || fn == FUNC_HYP))
                begin
                    use_rom = 1'b1;
                    src     = i;
                    halves  = 0;
                end
                else if (pass == 0)
                begin
                    halves = halves + 1;
                end
                if (n == p)
                begin
                    r.active   = 1'b1;
                    r.shift    = 6'(i);
                    cap_rom    = use_rom;
                    cap_src    = src;
                    cap_halves = halves;
                end
                n = n + 1;
            end
            if (passes == 2)
                rep = rep * 3 + 1;
        end
        if (r.active)
        begin
            if (cap_rom)
                step = sext64(rom_entry(fn == FUNC_HYP, cap_src));
            else
                step = sext64(64'd2 << FRAC_BITS);
            step   = 64'($signed(step) >>> cap_halves);
            r.step = step[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    localparam int PASSES_CIRC = pass_count(FUNC_CIRC);
    localparam int PASSES_HYP  = pass_count(FUNC_HYP);
    localparam int NUM_PASSES  = (PASSES_CIRC > PASSES_HYP) ? PASSES_CIRC : PASSES_HYP;

    localparam logic [63:0] GAIN_CIRC_Q = inv_sqrt_frac(gain_prod(1'b0));
    localparam logic [63:0] GAIN_HYP_Q  = inv_sqrt_frac(gain_prod(1'b1));

    // gains as positive multiplier operands
    localparam logic [DATA_WIDTH-1:0] GAIN_CIRC  = {1'b0, GAIN_CIRC_Q[DATA_WIDTH-2:0]};
    localparam logic [DATA_WIDTH-1:0] GAIN_HYP   = {1'b0, GAIN_HYP_Q[DATA_WIDTH-2:0]};
    localparam logic [DATA_WIDTH-1:0] GAIN_UNITY = DATA_WIDTH'(1) << FRAC_BITS;

endpackage

### rtl/uce_rotator.sv
// input register and the chain of shift-add cordic pass stages
module uce_rotator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  uce_pkg::beat_t in_beat,
    output logic           tail_valid,
    output uce_pkg::beat_t tail_beat
);

    localparam int DW = uce_pkg::DATA_WIDTH;
    localparam int NP = uce_pkg::NUM_PASSES;

    logic           valid_reg [0:NP];
    uce_pkg::beat_t beat_reg  [0:NP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (adv)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            beat_reg[0] <= in_beat;
    end

    for (genvar k = 0; k < NP; k++)
    begin : g_pass
        localparam uce_pkg::sched_t SC = uce_pkg::pass_sched(uce_pkg::FUNC_CIRC, k);
        localparam uce_pkg::sched_t SL = uce_pkg::pass_sched(uce_pkg::FUNC_LIN, k);
        localparam uce_pkg::sched_t SH = uce_pkg::pass_sched(uce_pkg::FUNC_HYP, k);

        uce_pkg::beat_t        beat_next;
        logic signed [DW-1:0]  xs;
        logic signed [DW-1:0]  ys;
        logic signed [DW-1:0]  zs;
        logic signed [DW-1:0]  tx;
        logic signed [DW-1:0]  ty;
        logic signed [DW-1:0]  step;
        logic                  act;
        logic                  dir;

        always_comb
        begin
            xs = beat_reg[k].x;
            ys = beat_reg[k].y;
            zs = beat_reg[k].z;
            case (beat_reg[k].func)
                uce_pkg::FUNC_CIRC:
                begin
                    act  = SC.active;
                    tx   = xs >>> SC.shift;
                    ty   = ys >>> SC.shift;
                    step = SC.step;
                end
                uce_pkg::FUNC_HYP:
                begin
                    act  = SH.active;
                    tx   = xs >>> SH.shift;
                    ty   = -(ys >>> SH.shift);
                    step = SH.step;
                end
                default:
                begin
                    // linear and the spare code: x stays put
                    act  = SL.active;
                    tx   = xs >>> SL.shift;
                    ty   = '0;
                    step = SL.step;
                end
            endcase
            dir       = beat_reg[k].vec ? !ys[DW-1] : zs[DW-1];
            beat_next = beat_reg[k];
            if (act)
            begin
                if (dir)
                begin
                    beat_next.z = zs + step;
                    beat_next.x = xs + ty;
                    beat_next.y = ys - tx;
                end
                else
                begin
                    beat_next.z = zs - step;
                    beat_next.x = xs - ty;
                    beat_next.y = ys + tx;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (adv)
                valid_reg[k+1] <= valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                beat_reg[k+1] <= beat_next;
        end
    end

    assign tail_valid = valid_reg[NP];
    assign tail_beat  = beat_reg[NP];

endmodule

### rtl/uce_scale.sv
// gain compensation stage: one registered multiply for x and for y
module uce_scale (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  uce_pkg::beat_t in_beat,
    output logic           out_valid,
    output uce_pkg::res_t  out_res
);

    localparam int DW = uce_pkg::DATA_WIDTH;
    localparam int FB = uce_pkg::FRAC_BITS;

    logic signed [DW-1:0]   gs;
    logic signed [DW-1:0]   xs;
    logic signed [DW-1:0]   ys;
    logic signed [2*DW-1:0] px_next;
    logic signed [2*DW-1:0] py_next;
    logic signed [2*DW-1:0] px_reg;
    logic signed [2*DW-1:0] py_reg;
    logic [DW-1:0]          z_reg;
    logic                   valid_reg;

    always_comb
    begin
        case (in_beat.func)
            uce_pkg::FUNC_CIRC: gs = uce_pkg::GAIN_CIRC;
            uce_pkg::FUNC_HYP:  gs = uce_pkg::GAIN_HYP;
            // unity gain keeps linear results exact
            default:            gs = uce_pkg::GAIN_UNITY;
        endcase
        xs      = in_beat.x;
        ys      = in_beat.y;
        px_next = xs * gs;
        py_next = ys * gs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            z_reg  <= in_beat.z;
        end
    end

    // floor of the product back at the fraction point
    assign out_valid = valid_reg;
    assign out_res.x = px_reg[FB +: DW];
    assign out_res.y = py_reg[FB +: DW];
    assign out_res.z = z_reg;

endmodule

### rtl/uce_skid.sv
// output register with one skid entry so the pipeline keeps moving while a result waits
module uce_skid (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  uce_pkg::res_t push_res,
    output logic          full,
    output logic          out_valid,
    input  logic          out_ready,
    output uce_pkg::res_t out_res
);

    logic          out_valid_reg;
    logic          out_valid_next;
    uce_pkg::res_t out_res_reg;
    uce_pkg::res_t out_res_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    uce_pkg::res_t skid_res_reg;
    uce_pkg::res_t skid_res_next;
    logic          out_free;

    always_comb
    begin
        out_free        = !out_valid_reg || out_ready;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // no push can arrive while the skid entry is taken
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_res_next   = push_res;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

### rtl/unified_cordic_engine.sv
// top level of the pipelined circular, linear and hyperbolic cordic engine
//
// channel  direction  handshake            fields
// in       to block   in_valid, in_ready   func, vectoring, x_in, y_in, z_in
// out      from block out_valid, out_ready x_out, y_out, z_out
//
// one beat per cycle while the pipeline advances; a result passes through the input register,
// 30 pass stages (hyperbolic schedule with its repeats), the multiplier register and the
// output register
// reset clears the valid bits only; angle tables and gains are constants
// the pipeline holds as a whole only while the multiplier stage has a beat and the
// skid entry is taken, so one waiting result does not stop input
`include "unified_cordic_engine_macros.svh"

module unified_cordic_engine (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [1:0]                              func,
    input  logic                                    vectoring,
    input  logic signed [uce_pkg::DATA_WIDTH-1:0]   x_in,
    input  logic signed [uce_pkg::DATA_WIDTH-1:0]   y_in,
    input  logic signed [uce_pkg::DATA_WIDTH-1:0]   z_in,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [uce_pkg::DATA_WIDTH-1:0]   x_out,
    output logic signed [uce_pkg::DATA_WIDTH-1:0]   y_out,
    output logic signed [uce_pkg::DATA_WIDTH-1:0]   z_out
);

    uce_pkg::beat_t in_beat;
    uce_pkg::beat_t tail_beat;
    uce_pkg::res_t  scale_res;
    uce_pkg::res_t  res;
    logic           tail_valid;
    logic           scale_valid;
    logic           skid_full;
    logic           adv;
    logic           push;

    always_comb
    begin
        in_beat.func = func;
        in_beat.vec  = vectoring;
        in_beat.x    = x_in;
        in_beat.y    = y_in;
        in_beat.z    = z_in;
    end

    // advance unless the last stage would have nowhere to go
    assign adv      = !(scale_valid && skid_full);
    assign push     = adv && scale_valid;
    assign in_ready = adv;

    uce_rotator u_rotator (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (in_valid),
        .in_beat    (in_beat),
        .tail_valid (tail_valid),
        .tail_beat  (tail_beat)
    );

    uce_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (tail_valid),
        .in_beat   (tail_beat),
        .out_valid (scale_valid),
        .out_res   (scale_res)
    );

    uce_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (scale_res),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    assign x_out = res.x;
    assign y_out = res.y;
    assign z_out = res.z;

    `UCE_ASSERT_IMPL(a_skid_behind_output, skid_full, out_valid, "skid entry taken with empty output")
    `UCE_ASSERT_NEXT(a_stall_keeps_tail, scale_valid && skid_full, scale_valid, "stalled beat lost")
    `UCE_ASSERT_NEXT(a_skid_kept, skid_full && !out_ready, skid_full, "skid beat dropped in stall")

endmodule
